### rtl/dlr_pkg.sv
// Shared codes for the DDA line rasterizer.
package dlr_pkg;

  // Function select carried on in_tuser.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

endpackage

### rtl/dda_line_rasterizer_core.sv
// DDA line rasterizer core: setup divider, fixed-point stepper and output register.

// A start beat (in_tuser = FUNC_START) carries two endpoints. The start pixel
// goes out on the cycle after acceptance. The minor-axis increment then comes
// from a restoring divider that resolves one quotient bit a cycle, and the core
// stays busy until all FRAC_BITS quotient bits are resolved. Lines whose |dx|
// equals |dy|, and zero-length lines, need no division. Each advance beat
// (FUNC_ADVANCE) produces the next pixel, with out_tlast set on the end point.
// An advance beat with no line in progress is consumed and yields nothing. A
// start beat abandons any line in progress. Input is taken when no division
// is running and the output register is free or being drained.
module dda_line_rasterizer_core
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 16,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // x_start, y_start, x_end, y_end (lowest bits first), zero padded
  input  logic [IN_W-1:0]  in_tdata,
  // func
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // pixel_x, pixel_y (lowest bits first), zero padded
  output logic [OUT_W-1:0] out_tdata,
  output logic             out_tlast
);

  localparam int CB = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = CB + F;        // biased position, never negative
  localparam int IW = F + 2;         // signed Q1.F increment
  localparam int CW = $clog2(F);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DIV  = 1'b1;

  localparam logic [IW-1:0] ONE = {2'b01, {F{1'b0}}};

  logic          state_r, state_nxt;
  logic          active_r, active_nxt;
  logic [CB-1:0] steps_left_r, steps_left_nxt;
  logic [PW-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [IW-1:0] inc_x_r, inc_x_nxt, inc_y_r, inc_y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CB-1:0] pix_x_r, pix_x_nxt, pix_y_r, pix_y_nxt;
  logic          last_r, last_nxt;

  // divider
  logic [CB-1:0] rem_r, rem_nxt;
  logic [CB-1:0] div_r, div_nxt;
  logic [F-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          x_major_r, x_major_nxt;
  logic          minor_neg_r, minor_neg_nxt;

  logic          in_fire;
  logic [CB-1:0] xs, ys, xe, ye, adx, ady, steps_w, minor_w;
  logic          x_neg, y_neg, x_major_w;
  logic [CB:0]   rem_sh, rem_diff;
  logic          q_bit;
  logic [F-1:0]  quo_fin;
  logic [IW-1:0] minor_inc;
  logic [PW-1:0] adv_x, adv_y;

  assign xs = in_tdata[CB-1:0];
  assign ys = in_tdata[2*CB-1:CB];
  assign xe = in_tdata[3*CB-1:2*CB];
  assign ye = in_tdata[4*CB-1:3*CB];

  assign x_neg     = xe < xs;
  assign y_neg     = ye < ys;
  assign adx       = x_neg ? (xs - xe) : (xe - xs);
  assign ady       = y_neg ? (ys - ye) : (ye - ys);
  assign x_major_w = adx >= ady;
  assign steps_w   = x_major_w ? adx : ady;
  assign minor_w   = x_major_w ? ady : adx;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  // one restoring step: remainder stays below the divisor
  assign rem_sh    = {rem_r, 1'b0};
  assign rem_diff  = rem_sh - {1'b0, div_r};
  assign q_bit     = !rem_diff[CB];
  assign quo_fin   = {quo_r[F-2:0], q_bit};
  assign minor_inc = minor_neg_r ? (IW'(0) - {2'b00, quo_fin}) : {2'b00, quo_fin};

  assign adv_x = pos_x_r + {{(PW-IW){inc_x_r[IW-1]}}, inc_x_r};
  assign adv_y = pos_y_r + {{(PW-IW){inc_y_r[IW-1]}}, inc_y_r};

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    steps_left_nxt = steps_left_r;
    pos_x_nxt      = pos_x_r;
    pos_y_nxt      = pos_y_r;
    inc_x_nxt      = inc_x_r;
    inc_y_nxt      = inc_y_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    pix_x_nxt      = pix_x_r;
    pix_y_nxt      = pix_y_r;
    last_nxt       = last_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    x_major_nxt    = x_major_r;
    minor_neg_nxt  = minor_neg_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_tuser == FUNC_START) begin
            pos_x_nxt      = {xs, 1'b1, {(F-1){1'b0}}};
            pos_y_nxt      = {ys, 1'b1, {(F-1){1'b0}}};
            out_valid_nxt  = 1'b1;
            pix_x_nxt      = xs;
            pix_y_nxt      = ys;
            last_nxt       = (steps_w == '0);
            steps_left_nxt = steps_w;
            active_nxt     = (steps_w != '0);
            inc_x_nxt      = x_neg ? (IW'(0) - ONE) : ONE;
            inc_y_nxt      = y_neg ? (IW'(0) - ONE) : ONE;
            x_major_nxt    = x_major_w;
            minor_neg_nxt  = x_major_w ? y_neg : x_neg;
            rem_nxt        = minor_w;
            div_nxt        = steps_w;
            quo_nxt        = '0;
            cnt_nxt        = '0;
            if (steps_w == '0) begin
              inc_x_nxt = '0;
              inc_y_nxt = '0;
            end else if (adx != ady) begin
              state_nxt = S_DIV;
            end
          end else if (active_r) begin
            pos_x_nxt      = adv_x;
            pos_y_nxt      = adv_y;
            out_valid_nxt  = 1'b1;
            pix_x_nxt      = adv_x[PW-1:F];
            pix_y_nxt      = adv_y[PW-1:F];
            last_nxt       = (steps_left_r == CB'(1));
            steps_left_nxt = steps_left_r - CB'(1);
            active_nxt     = (steps_left_r != CB'(1));
          end
        end
      end
      S_DIV: begin
        rem_nxt = q_bit ? rem_diff[CB-1:0] : rem_sh[CB-1:0];
        quo_nxt = quo_fin;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(F - 1)) begin
          state_nxt = S_IDLE;
          if (x_major_r) begin
            inc_y_nxt = minor_inc;
          end else begin
            inc_x_nxt = minor_inc;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      steps_left_r <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      steps_left_r <= steps_left_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r     <= pos_x_nxt;
    pos_y_r     <= pos_y_nxt;
    inc_x_r     <= inc_x_nxt;
    inc_y_r     <= inc_y_nxt;
    pix_x_r     <= pix_x_nxt;
    pix_y_r     <= pix_y_nxt;
    last_r      <= last_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    x_major_r   <= x_major_nxt;
    minor_neg_r <= minor_neg_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({pix_y_r, pix_x_r});
  assign out_tlast  = last_r;

  // a line in progress always has points left
  a_active_steps: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (steps_left_r != '0))
    else $error("active line with no steps left");

  // a start with unequal deltas launches the divider
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tuser == FUNC_START) && (adx != ady)) |=> (state_r == S_DIV))
    else $error("divider not started");

  // a held beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(pix_x_r) && $stable(pix_y_r)))
    else $error("pending output lost");

endmodule
